// ----- rtl/gsd_pkg.sv -----
`timescale 1ns / 1ps

package gsd_pkg;

  // Default data widths
  localparam int unsigned AXIS_BITS_DEF = 16;
  localparam int unsigned TRIG_BITS_DEF = 16;

  // Configuration register widths and port widths
  localparam int unsigned SDZ_W  = 15;
  localparam int unsigned TDZ_W  = 16;
  localparam int unsigned CFG_DW = 16;
  localparam int unsigned CFG_IW = 3;

  // Register index map
  typedef enum logic [CFG_IW-1:0] {
    CFG_LEFT_STICK_DZ  = 3'd0,
    CFG_RIGHT_STICK_DZ = 3'd1,
    CFG_LEFT_TRIG_DZ   = 3'd2,
    CFG_RIGHT_TRIG_DZ  = 3'd3
  } cfg_idx_e;

  // Per-axis control bits handed from the stick front end to the divider
  typedef struct packed {
    logic neg;   // result sign
    logic zero;  // pair lies inside the dead zone
  } div_flags_t;

endpackage

// ----- rtl/gsd_div.sv -----
`timescale 1ns / 1ps

// Pipelined restoring divider: one quotient bit per stage, then sign and saturate.
module gsd_div import gsd_pkg::*; #(
  parameter int unsigned AxisBits = AXIS_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic [AxisBits-1:0]        num_i,   // |mag|, numerator is num * one
  input  logic [AxisBits-1:0]        den_i,   // one - dz
  input  div_flags_t                 flags_i,
  output logic signed [AxisBits-1:0] res_o
);

  localparam int unsigned A = AxisBits;
  localparam logic [A-1:0] MaxPos = {1'b0, {(A-1){1'b1}}};
  localparam logic [A-1:0] MinNeg = {1'b1, {(A-1){1'b0}}};

  logic [A-1:0] rem_q [0:A-1];
  logic [A-1:0] quo_q [0:A];
  logic [A-1:0] den_q [0:A-1];
  div_flags_t   flg_q [0:A];
  logic         ovf_q [0:A];
  logic         lsb0_q;
  logic [A-1:0] mag;
  logic [A-1:0] res_d, res_q;

  // Entry stage: quotient overflow when num >= 2 * den, remainder seeded with num / 2
  always_ff @(posedge clk_i) begin
    rem_q[0] <= num_i >> 1;
    quo_q[0] <= '0;
    den_q[0] <= den_i;
    flg_q[0] <= flags_i;
    ovf_q[0] <= {1'b0, num_i} >= {den_i, 1'b0};
    lsb0_q   <= num_i[0];
  end

  // One quotient bit per stage; only the top bit of the low numerator can be set
  for (genvar k = 0; k < A; k++) begin : g_stage
    logic [A:0] shf;
    logic [A:0] dif;
    logic       take;

    if (k == 0) begin : g_first
      assign shf = {rem_q[k], lsb0_q};
    end else begin : g_rest
      assign shf = {rem_q[k], 1'b0};
    end
    assign take = shf >= {1'b0, den_q[k]};
    assign dif  = shf - {1'b0, den_q[k]};

    always_ff @(posedge clk_i) begin
      quo_q[k+1] <= {quo_q[k][A-2:0], take};
      flg_q[k+1] <= flg_q[k];
      ovf_q[k+1] <= ovf_q[k];
    end

    // Remainder and divisor are not needed past the last quotient bit
    if (k < A - 1) begin : g_carry
      always_ff @(posedge clk_i) begin
        rem_q[k+1] <= take ? dif[A-1:0] : shf[A-1:0];
        den_q[k+1] <= den_q[k];
      end
    end
  end

  // Sign and saturate
  assign mag = ovf_q[A] ? '1 : quo_q[A];

  always_comb begin
    if (flg_q[A].zero) begin
      res_d = '0;
    end else if (!flg_q[A].neg) begin
      res_d = (mag > MaxPos) ? MaxPos : mag;
    end else begin
      res_d = (mag > MaxPos) ? MinNeg : (~mag + 1'b1);
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_o = signed'(res_q);

endmodule

// ----- rtl/gsd_stick.sv -----
`timescale 1ns / 1ps

// One stick: squares and offsets, radial test, then one divider per axis.
module gsd_stick import gsd_pkg::*; #(
  parameter int unsigned AxisBits = AXIS_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic signed [AxisBits-1:0] x_i,
  input  logic signed [AxisBits-1:0] y_i,
  input  logic [SDZ_W-1:0]           dz_cfg_i,
  output logic signed [AxisBits-1:0] out_x_o,
  output logic signed [AxisBits-1:0] out_y_o
);

  localparam int unsigned A  = AxisBits;
  localparam int unsigned EW = (A - 1 > SDZ_W) ? A - 1 : SDZ_W;
  localparam logic [EW-1:0] DzMax = EW'({(A-1){1'b1}});

  logic [EW-1:0]  dz_ext;
  logic [A-2:0]   dz;
  logic [A-1:0]   ax, ay;

  logic [2*A-1:0] x2_q, y2_q;
  logic [2*A-3:0] dz2_q;
  logic [A:0]     magx_q, magy_q;
  logic           negx_q, negy_q;
  logic [A-1:0]   den_q;

  logic [2*A:0]   rad;
  logic           in_dz;
  logic [A:0]     absx, absy;

  logic [A-1:0]   numx_q, numy_q, den2_q;
  div_flags_t     flgx_q, flgy_q;

  // Dead zone clamped below one
  assign dz_ext = EW'(dz_cfg_i);
  assign dz     = (dz_ext > DzMax) ? DzMax[A-2:0] : dz_ext[A-2:0];

  assign ax = x_i[A-1] ? (~x_i + 1'b1) : x_i;
  assign ay = y_i[A-1] ? (~y_i + 1'b1) : y_i;

  // Stage 1: squares, axis offsets, divisor
  always_ff @(posedge clk_i) begin
    x2_q   <= ax * ax;
    y2_q   <= ay * ay;
    dz2_q  <= dz * dz;
    magx_q <= {1'b0, ax} - {2'b00, dz};
    magy_q <= {1'b0, ay} - {2'b00, dz};
    negx_q <= x_i[A-1];
    negy_q <= y_i[A-1];
    den_q  <= {1'b1, {(A-1){1'b0}}} - {1'b0, dz};
  end

  // Stage 2: radial test, magnitude and sign of each offset
  assign rad    = {1'b0, x2_q} + {1'b0, y2_q};
  assign in_dz  = rad <= (2*A+1)'(dz2_q);
  assign absx   = magx_q[A] ? (~magx_q + 1'b1) : magx_q;
  assign absy   = magy_q[A] ? (~magy_q + 1'b1) : magy_q;

  always_ff @(posedge clk_i) begin
    numx_q      <= absx[A-1:0];
    numy_q      <= absy[A-1:0];
    den2_q      <= den_q;
    flgx_q.neg  <= negx_q ^ magx_q[A];
    flgy_q.neg  <= negy_q ^ magy_q[A];
    flgx_q.zero <= in_dz;
    flgy_q.zero <= in_dz;
  end

  gsd_div #(.AxisBits(A)) u_div_x (
    .clk_i  (clk_i),
    .num_i  (numx_q),
    .den_i  (den2_q),
    .flags_i(flgx_q),
    .res_o  (out_x_o)
  );

  gsd_div #(.AxisBits(A)) u_div_y (
    .clk_i  (clk_i),
    .num_i  (numy_q),
    .den_i  (den2_q),
    .flags_i(flgy_q),
    .res_o  (out_y_o)
  );

endmodule

// ----- rtl/gamepad_stick_trigger_deadzone.sv -----
`timescale 1ns / 1ps

// Channel   Handshake           Payload
// --------  ------------------  --------------------------------------------
// reading   start / busy        four stick axes, two raw triggers
// result    done_o (strobe)     four conditioned axes, two trigger outputs
// config    cfg_we_i            cfg_idx_i, cfg_data_i
//
// A word is taken every cycle that start is high; busy is tied low.
// Pipeline: two front stages (squares, radial test), the divider entry stage,
// one quotient bit per stage, and the sign/saturate stage.
// Reset clears the dead zones and the valid pipe; data registers are not reset.
// The receiver cannot stall, so the pipeline never holds.
module gamepad_stick_trigger_deadzone import gsd_pkg::*; #(
  parameter int unsigned AxisBits = AXIS_BITS_DEF,
  parameter int unsigned TrigBits = TRIG_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic                       cfg_we_i,
  input  logic [CFG_IW-1:0]          cfg_idx_i,
  input  logic [CFG_DW-1:0]          cfg_data_i,
  input  logic signed [AxisBits-1:0] left_stick_x_i,
  input  logic signed [AxisBits-1:0] left_stick_y_i,
  input  logic signed [AxisBits-1:0] right_stick_x_i,
  input  logic signed [AxisBits-1:0] right_stick_y_i,
  input  logic [TrigBits-1:0]        left_trigger_raw_i,
  input  logic [TrigBits-1:0]        right_trigger_raw_i,
  output logic                       done_o,
  output logic signed [AxisBits-1:0] left_out_x_o,
  output logic signed [AxisBits-1:0] left_out_y_o,
  output logic signed [AxisBits-1:0] right_out_x_o,
  output logic signed [AxisBits-1:0] right_out_y_o,
  output logic [TrigBits-1:0]        left_trigger_out_o,
  output logic [TrigBits-1:0]        right_trigger_out_o
);

  localparam int unsigned Lat = AxisBits + 4;

  logic [SDZ_W-1:0]    lsdz_q, rsdz_q;
  logic [TDZ_W-1:0]    ltdz_q, rtdz_q;
  logic [Lat-1:0]      vld_d, vld_q;
  logic                accept;
  logic [TrigBits-1:0] ltdz, rtdz, ltrig, rtrig;
  logic [TrigBits-1:0] ltrig_q [0:Lat-1];
  logic [TrigBits-1:0] rtrig_q [0:Lat-1];

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lsdz_q <= '0;
      rsdz_q <= '0;
      ltdz_q <= '0;
      rtdz_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_LEFT_STICK_DZ:  lsdz_q <= cfg_data_i[SDZ_W-1:0];
        CFG_RIGHT_STICK_DZ: rsdz_q <= cfg_data_i[SDZ_W-1:0];
        CFG_LEFT_TRIG_DZ:   ltdz_q <= cfg_data_i[TDZ_W-1:0];
        CFG_RIGHT_TRIG_DZ:  rtdz_q <= cfg_data_i[TDZ_W-1:0];
        default: ;
      endcase
    end
  end

  // Valid pipe, aligned with the divider output
  assign vld_d = {vld_q[Lat-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign done_o = vld_q[Lat-1];

  // Triggers: subtract at entry, then delay to match the sticks
  assign ltdz  = TrigBits'(ltdz_q);
  assign rtdz  = TrigBits'(rtdz_q);
  assign ltrig = (left_trigger_raw_i > ltdz) ? (left_trigger_raw_i - ltdz) : '0;
  assign rtrig = (right_trigger_raw_i > rtdz) ? (right_trigger_raw_i - rtdz) : '0;

  always_ff @(posedge clk_i) begin
    ltrig_q[0] <= ltrig;
    rtrig_q[0] <= rtrig;
    for (int i = 1; i < Lat; i++) begin
      ltrig_q[i] <= ltrig_q[i-1];
      rtrig_q[i] <= rtrig_q[i-1];
    end
  end

  assign left_trigger_out_o  = ltrig_q[Lat-1];
  assign right_trigger_out_o = rtrig_q[Lat-1];

  gsd_stick #(.AxisBits(AxisBits)) u_left (
    .clk_i   (clk_i),
    .x_i     (left_stick_x_i),
    .y_i     (left_stick_y_i),
    .dz_cfg_i(lsdz_q),
    .out_x_o (left_out_x_o),
    .out_y_o (left_out_y_o)
  );

  gsd_stick #(.AxisBits(AxisBits)) u_right (
    .clk_i   (clk_i),
    .x_i     (right_stick_x_i),
    .y_i     (right_stick_y_i),
    .dz_cfg_i(rsdz_q),
    .out_x_o (right_out_x_o),
    .out_y_o (right_out_y_o)
  );

`ifndef SYNTHESIS
  // A result appears only for a word taken at the input
  a_done_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, Lat))
    else $error("result without matching input word");

  // Trigger output never exceeds its raw value
  a_ltrig_le: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (left_trigger_out_o <= $past(left_trigger_raw_i, Lat)))
    else $error("left trigger output above raw value");

  // A centered stick always reads zero
  a_left_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(left_stick_x_i, Lat) == '0 && $past(left_stick_y_i, Lat) == '0)
    |-> (left_out_x_o == '0 && left_out_y_o == '0))
    else $error("centered left stick not zero");
`endif

endmodule

// ----- bench/tb_gamepad_stick_trigger_deadzone.sv -----
`timescale 1ns / 1ps

module tb_gamepad_stick_trigger_deadzone;
  import gsd_pkg::*;

  localparam int unsigned AW = AXIS_BITS_DEF;
  localparam int unsigned TW = TRIG_BITS_DEF;
  localparam longint      AXIS_ONE = longint'(1) << (AW - 1);
  localparam int          DUT_LATENCY = AW + 4;
  localparam int          PHASE_ITEMS = 155;
  // indexes outside the register map; writes there must be dropped
  localparam logic [CFG_IW-1:0] CFG_UNMAPPED_LO = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_UNMAPPED_HI = 3'd7;

  typedef struct {
    logic signed [AW-1:0] lx, ly, rx, ry;
    logic [TW-1:0]        lt, rt;
  } pad_word_t;

  logic clk_i, rst_ni, busy, cfg_we_i, done_o;
  logic start = 1'b0;
  logic [CFG_IW-1:0] cfg_idx_i;
  logic [CFG_DW-1:0] cfg_data_i;
  logic signed [AW-1:0] left_stick_x_i = '0;
  logic signed [AW-1:0] left_stick_y_i = '0;
  logic signed [AW-1:0] right_stick_x_i = '0;
  logic signed [AW-1:0] right_stick_y_i = '0;
  logic [TW-1:0] left_trigger_raw_i = '0;
  logic [TW-1:0] right_trigger_raw_i = '0;
  logic signed [AW-1:0] left_out_x_o, left_out_y_o, right_out_x_o, right_out_y_o;
  logic [TW-1:0] left_trigger_out_o, right_trigger_out_o;

  gamepad_stick_trigger_deadzone dut (
    .clk_i, .rst_ni, .start, .busy, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .left_stick_x_i, .left_stick_y_i, .right_stick_x_i, .right_stick_y_i,
    .left_trigger_raw_i, .right_trigger_raw_i, .done_o,
    .left_out_x_o, .left_out_y_o, .right_out_x_o, .right_out_y_o,
    .left_trigger_out_o, .right_trigger_out_o
  );

  // dead zone shadow copies, tracked from the write port
  logic [SDZ_W-1:0] lsdz = '0;
  logic [SDZ_W-1:0] rsdz = '0;
  logic [TDZ_W-1:0] ltdz = '0;
  logic [TDZ_W-1:0] rtdz = '0;

  pad_word_t readings_q[$];
  pad_word_t conditioned_q[$];
  int  mismatches = 0;
  bit  failed = 0;
  bit  taken = 0;
  int  gap = 0;
  bit  no_gaps = 0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  initial begin
    #10ms;
    $display("status: fail");
    $finish;
  end

  // sign(v) * (|v| - dz) * one / (one - dz), truncated, then saturated
  function automatic logic signed [AW-1:0] rescale(longint v, longint dz);
    longint mag, r;
    mag = (v < 0 ? -v : v) - dz;
    r = (mag * AXIS_ONE) / (AXIS_ONE - dz);
    if (v < 0) r = -r;
    if (r > AXIS_ONE - 1) r = AXIS_ONE - 1;
    if (r < -AXIS_ONE) r = -AXIS_ONE;
    return r[AW-1:0];
  endfunction

  function automatic pad_word_t condition_pad(pad_word_t w);
    pad_word_t o;
    longint x, y, ld, rd;
    ld = lsdz;
    rd = rsdz;
    if (ld > AXIS_ONE - 1) ld = AXIS_ONE - 1;
    if (rd > AXIS_ONE - 1) rd = AXIS_ONE - 1;
    x = w.lx;
    y = w.ly;
    o.lx = '0;
    o.ly = '0;
    if (x * x + y * y > ld * ld) begin
      o.lx = rescale(x, ld);
      o.ly = rescale(y, ld);
    end
    x = w.rx;
    y = w.ry;
    o.rx = '0;
    o.ry = '0;
    if (x * x + y * y > rd * rd) begin
      o.rx = rescale(x, rd);
      o.ry = rescale(y, rd);
    end
    o.lt = (w.lt > ltdz) ? w.lt - ltdz : '0;
    o.rt = (w.rt > rtdz) ? w.rt - rtdz : '0;
    return o;
  endfunction

  function automatic void check_field(string name, longint exp_v, longint act_v);
    if (exp_v != act_v) begin
      failed = 1;
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d, got %0d", name, exp_v, act_v);
    end
  endfunction

  // monitor: config shadow, acceptance, result check
  always @(posedge clk_i) begin
    pad_word_t w, e;
    taken <= start && !busy;
    if (rst_ni && cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LEFT_STICK_DZ:  lsdz <= cfg_data_i[SDZ_W-1:0];
        CFG_RIGHT_STICK_DZ: rsdz <= cfg_data_i[SDZ_W-1:0];
        CFG_LEFT_TRIG_DZ:   ltdz <= cfg_data_i[TDZ_W-1:0];
        CFG_RIGHT_TRIG_DZ:  rtdz <= cfg_data_i[TDZ_W-1:0];
        default: ;
      endcase
    end
    if (rst_ni && done_o) begin
      if (conditioned_q.size() == 0) begin
        failed = 1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word");
      end else begin
        e = conditioned_q.pop_front();
        check_field("left_out_x", e.lx, left_out_x_o);
        check_field("left_out_y", e.ly, left_out_y_o);
        check_field("right_out_x", e.rx, right_out_x_o);
        check_field("right_out_y", e.ry, right_out_y_o);
        check_field("left_trigger_out", e.lt, left_trigger_out_o);
        check_field("right_trigger_out", e.rt, right_trigger_out_o);
      end
    end
    if (rst_ni && start && !busy) begin
      w.lx = left_stick_x_i;
      w.ly = left_stick_y_i;
      w.rx = right_stick_x_i;
      w.ry = right_stick_y_i;
      w.lt = left_trigger_raw_i;
      w.rt = right_trigger_raw_i;
      conditioned_q.push_back(condition_pad(w));
    end
  end

  // driver: one reading word per handshake, random gaps unless no_gaps is set
  always @(negedge clk_i) begin
    pad_word_t w;
    if (rst_ni && (!start || taken)) begin
      if (gap > 0) begin
        gap <= gap - 1;
        start <= 1'b0;
      end else if (readings_q.size() > 0) begin
        w = readings_q.pop_front();
        left_stick_x_i      <= w.lx;
        left_stick_y_i      <= w.ly;
        right_stick_x_i     <= w.rx;
        right_stick_y_i     <= w.ry;
        left_trigger_raw_i  <= w.lt;
        right_trigger_raw_i <= w.rt;
        start <= 1'b1;
        gap <= no_gaps ? 0 : $urandom_range(0, 14);
      end else begin
        start <= 1'b0;
      end
    end
  end

  function automatic pad_word_t mk(longint lx, longint ly, longint rx, longint ry,
                                   longint lt, longint rt);
    pad_word_t w;
    w.lx = lx[AW-1:0];
    w.ly = ly[AW-1:0];
    w.rx = rx[AW-1:0];
    w.ry = ry[AW-1:0];
    w.lt = lt[TW-1:0];
    w.rt = rt[TW-1:0];
    return w;
  endfunction

  function automatic longint rand_axis(longint dz);
    longint v;
    case ($urandom_range(0, 5))
      0, 1: v = $signed(16'($urandom));
      2: v = dz + $urandom_range(0, 4) - 2;
      3: v = ($urandom_range(0, 1) != 0) ? AXIS_ONE - 1 : -AXIS_ONE;
      4: v = $urandom_range(0, int'(dz));
      default: v = int'($urandom_range(0, 3)) - 1;
    endcase
    if (v > AXIS_ONE - 1) v = AXIS_ONE - 1;
    if ($urandom_range(0, 1) != 0) v = -v;
    if (v < -AXIS_ONE) v = -AXIS_ONE;
    return v;
  endfunction

  function automatic longint rand_trigger(longint dz);
    longint v;
    case ($urandom_range(0, 3))
      0: v = dz + $urandom_range(0, 4) - 2;
      1: v = ($urandom_range(0, 1) != 0) ? 0 : 65535;
      default: v = $urandom_range(0, 65535);
    endcase
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return v;
  endfunction

  task automatic wait_idle();
    wait (readings_q.size() == 0 && !start && conditioned_q.size() == 0);
    repeat (DUT_LATENCY + 5) @(posedge clk_i);
  endtask

  task automatic write_dead_zones(logic [CFG_DW-1:0] ls, logic [CFG_DW-1:0] rs,
                                  logic [CFG_DW-1:0] lt, logic [CFG_DW-1:0] rt);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= CFG_LEFT_STICK_DZ;
    cfg_data_i <= ls;
    @(negedge clk_i);
    cfg_idx_i <= CFG_RIGHT_STICK_DZ;
    cfg_data_i <= rs;
    @(negedge clk_i);
    cfg_idx_i <= CFG_LEFT_TRIG_DZ;
    cfg_data_i <= lt;
    @(negedge clk_i);
    cfg_idx_i <= CFG_RIGHT_TRIG_DZ;
    cfg_data_i <= rt;
    @(negedge clk_i);
    cfg_idx_i <= ($urandom_range(0, 1) != 0) ? CFG_UNMAPPED_LO : CFG_UNMAPPED_HI;
    cfg_data_i <= 16'($urandom);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // stimulus phases
  initial begin
    logic [CFG_DW-1:0] ls, rs, lt, rt;
    cfg_we_i = 0;
    cfg_idx_i = CFG_LEFT_STICK_DZ;
    cfg_data_i = '0;
    rst_ni = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // reset dead zones: extremes pass straight through, full negative saturates
    readings_q.push_back(mk(0, 0, 0, 0, 0, 0));
    readings_q.push_back(mk(32767, -32768, -32768, -32768, 65535, 65535));
    readings_q.push_back(mk(-1, 1, 1, -1, 1, 0));
    wait_idle();

    // mid dead zones: within the radius, on it, just outside, reversed-sign axis
    write_dead_zones(16'd16384, 16'h8000 | 16'd16384, 16'd32768, 16'd32768);
    readings_q.push_back(mk(100, 100, -100, 50, 32767, 32768));
    readings_q.push_back(mk(16384, 0, 0, -16384, 32768, 32769));
    readings_q.push_back(mk(16385, 0, 0, -16385, 32769, 0));
    readings_q.push_back(mk(1000, 32767, -1000, -32768, 65535, 65535));
    readings_q.push_back(mk(12000, 12000, -12000, 12000, 0, 1));
    readings_q.push_back(mk(-32768, 16383, 32767, -16383, 1, 65534));
    wait_idle();

    // largest dead zones
    write_dead_zones(16'd32766, 16'hFFFF, 16'd65535, 16'd65535);
    readings_q.push_back(mk(32766, 0, 32767, 0, 65535, 65534));
    readings_q.push_back(mk(32767, 32767, -32768, -32768, 65535, 0));
    readings_q.push_back(mk(-32767, 1, 1, -32767, 0, 0));
    readings_q.push_back(mk(-32768, 0, 0, 32767, 12, 40000));
    readings_q.push_back(mk(23170, 23170, -23169, 23169, 65535, 65535));
    wait_idle();

    // random phases over a spread of settings
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: begin ls = 0; rs = 0; lt = 0; rt = 0; end
        1: begin ls = 16'd32766; rs = 16'd32766; lt = 16'hFFFF; rt = 16'hFFFF; end
        2: begin ls = 1; rs = 16'd2; lt = 1; rt = 16'hFFFE; end
        default: begin
          ls = 16'($urandom);
          rs = 16'($urandom_range(0, 8000));
          lt = 16'($urandom);
          rt = 16'($urandom_range(0, 8000));
        end
      endcase
      write_dead_zones(ls, rs, lt, rt);
      no_gaps = (p % 3 == 1);
      for (int i = 0; i < PHASE_ITEMS; i++)
        readings_q.push_back(mk(rand_axis(lsdz), rand_axis(lsdz), rand_axis(rsdz),
                                rand_axis(rsdz), rand_trigger(ltdz), rand_trigger(rtdz)));
      wait_idle();
    end

    if (!failed) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
